// ===== rtl/mmie_pkg.sv =====
// ----------------------------------------------------------------------------
// mmie_pkg
// Shared types, opcodes and constants for the memory-to-memory executor.
// ----------------------------------------------------------------------------
package mmie_pkg;

  localparam int unsigned DataWordsDef    = 256;
  localparam int unsigned ProgramWordsDef = 1024;
  localparam int unsigned LenW            = 11;
  localparam int unsigned PcW             = 10;

  localparam logic [4:0] ADD   = 5'd0;
  localparam logic [4:0] SOU   = 5'd1;
  localparam logic [4:0] MUL   = 5'd2;
  localparam logic [4:0] DIV   = 5'd3;
  localparam logic [4:0] COP   = 5'd4;
  localparam logic [4:0] PCOPA = 5'd5;
  localparam logic [4:0] PCOPB = 5'd6;
  localparam logic [4:0] AFC   = 5'd7;
  localparam logic [4:0] PRI   = 5'd8;
  localparam logic [4:0] INF   = 5'd9;
  localparam logic [4:0] SUP   = 5'd10;
  localparam logic [4:0] INFEQ = 5'd11;
  localparam logic [4:0] SUPEQ = 5'd12;
  localparam logic [4:0] EQU   = 5'd13;
  localparam logic [4:0] AND_  = 5'd14;
  localparam logic [4:0] OR_   = 5'd15;
  localparam logic [4:0] JMP   = 5'd16;
  localparam logic [4:0] JMF   = 5'd17;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_PTR  = 2'd2;

  typedef struct packed {
    logic [4:0]         func;
    logic [7:0]         dest_addr;
    logic [7:0]         src_a_addr;
    logic [7:0]         src_b_addr;
    logic signed [31:0] immediate;
    logic [9:0]         jump_target;
  } instr_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic               halted;
    logic               print_valid;
    logic [7:0]         print_addr;
    logic signed [31:0] print_value;
    logic [1:0]         status;
  } result_t;

  // Memory port selection driven by the controller.
  typedef enum logic [2:0] {
    RD_A, RD_B, RD_D, RD_PTR_A, WR_RES, WR_PTR, MP_NONE
  } mem_op_t;

  typedef struct packed {
    mem_op_t op;
    logic    load_instr;
    logic    capture_a;
    logic    capture_b;
    logic    capture_d;
    logic    capture_p;
    logic    div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_stat_t;

endpackage

// ===== rtl/mmie_div.sv =====
// ----------------------------------------------------------------------------
// mmie_div
// Signed truncating 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmie_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [31:0] quot
);
  logic [31:0] q;
  logic [31:0] dv;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic        neg;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], q[31]};
  assign trial   = shifted - {1'b0, dv};
  assign quot    = neg ? (32'd0 - q) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
      q    <= num[31] ? (32'd0 - num) : num;
      dv   <= den[31] ? (32'd0 - den) : den;
      neg  <= num[31] ^ den[31];
      rem  <= '0;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial;
        q   <= {q[30:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy |-> (cnt != 6'd0))
    else $error("divider busy with zero count");
endmodule

// ===== rtl/mmie_datapath.sv =====
// ----------------------------------------------------------------------------
// mmie_datapath
// Instruction register, data memory, operand registers, ALU and divider.
// ----------------------------------------------------------------------------
module mmie_datapath #(
  parameter int unsigned DATA_WORDS = mmie_pkg::DataWordsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  mmie_pkg::instr_t   instr,
  input  mmie_pkg::dp_cmd_t  cmd,
  output mmie_pkg::dp_stat_t stat,
  output mmie_pkg::instr_t   ir,
  output logic [31:0]        va,
  output logic [31:0]        vb,
  output logic [31:0]        vd,
  output logic               ptr_ok
);
  import mmie_pkg::*;
  localparam int unsigned AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  logic [31:0] mem [DATA_WORDS];
  logic [31:0] rdata;
  logic        rvalid_addr;
  logic [31:0] addr;
  logic        do_wr;
  logic [31:0] wdata;
  logic [31:0] quot;
  logic        in_rng;
  logic [31:0] alu_res;

  always_comb begin
    addr  = '0;
    do_wr = 1'b0;
    wdata = alu_res;
    case (cmd.op)
      RD_A:     addr = 32'(ir.src_a_addr);
      RD_B:     addr = 32'(ir.src_b_addr);
      RD_D:     addr = 32'(ir.dest_addr);
      RD_PTR_A: addr = va;
      WR_RES: begin addr = 32'(ir.dest_addr); do_wr = 1'b1; end
      WR_PTR: begin addr = vd; do_wr = 1'b1; wdata = va; end
      default: addr = '0;
    endcase
  end

  assign in_rng = (addr < 32'(DATA_WORDS));

  always_ff @(posedge clk) begin
    if (do_wr && in_rng) mem[addr[AW-1:0]] <= wdata;
    rdata <= mem[addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) rvalid_addr <= 1'b0;
    else     rvalid_addr <= in_rng;
  end

  // Out-of-range reads return zero; the indirect word lands in vd so the
  // pointer in va stays put for the range check.
  always_ff @(posedge clk) begin
    if (cmd.load_instr) ir <= instr;
    if (cmd.capture_a)  va <= rvalid_addr ? rdata : '0;
    if (cmd.capture_b)  vb <= rvalid_addr ? rdata : '0;
    if (cmd.capture_d)  vd <= rvalid_addr ? rdata : '0;
    if (cmd.capture_p)  vd <= rdata;
  end

  assign ptr_ok = !va[31] && (va < 32'(DATA_WORDS));

  mmie_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .num(va), .den(vb), .busy(stat.div_busy), .quot(quot)
  );

  always_comb begin
    case (ir.func)
      ADD:   alu_res = va + vb;
      SOU:   alu_res = va - vb;
      MUL:   alu_res = va * vb;
      DIV:   alu_res = (vb == '0) ? '0 : quot;
      PCOPA: alu_res = vd;
      INF:   alu_res = 32'($signed(va) < $signed(vb));
      SUP:   alu_res = 32'($signed(va) > $signed(vb));
      INFEQ: alu_res = 32'($signed(va) <= $signed(vb));
      SUPEQ: alu_res = 32'($signed(va) >= $signed(vb));
      EQU:   alu_res = 32'(va == vb);
      AND_:  alu_res = 32'((va != '0) && (vb != '0));
      OR_:   alu_res = 32'((va != '0) || (vb != '0));
      AFC:   alu_res = ir.immediate;
      default: alu_res = va;
    endcase
  end
endmodule

// ===== rtl/mmie_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmie_ctrl
// Sequencer: fetches operands, runs the operation, writes back, reports.
// ----------------------------------------------------------------------------
module mmie_ctrl #(
  parameter int unsigned DATA_WORDS = mmie_pkg::DataWordsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [10:0]        cfg_data,
  input  mmie_pkg::instr_t   ir,
  input  logic [31:0]        va,
  input  logic [31:0]        vb,
  input  logic [31:0]        vd,
  input  logic               ptr_ok,
  input  mmie_pkg::dp_stat_t stat,
  output mmie_pkg::dp_cmd_t  cmd,
  output mmie_pkg::result_t  res
);
  import mmie_pkg::*;
  localparam int unsigned PROGRAM_WORDS = ProgramWordsDef;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_CAP_B, S_OPS, S_DIV, S_PTR, S_PTR_CAP,
    S_WB, S_OUT
  } state_t;

  state_t      state;
  logic [10:0] plen;
  logic [10:0] pc;
  logic [10:0] len;
  logic [10:0] nxt;
  logic [1:0]  st;
  logic        waiting_div;

  function automatic logic ptr_ok_d();
    return !vd[31] && (vd < 32'(DATA_WORDS));
  endfunction

  assign len       = (plen > 11'(PROGRAM_WORDS)) ? 11'(PROGRAM_WORDS) : plen;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd            = '0;
    cmd.op         = MP_NONE;
    cmd.load_instr = (state == S_IDLE) && in_valid;
    case (state)
      S_RA:  cmd.op = (ir.func == PCOPB) ? RD_D : RD_A;
      S_RB: begin
        cmd.op = (ir.func == PCOPB) ? RD_A : RD_B;
        if (ir.func == PCOPB) cmd.capture_d = 1'b1;
        else                  cmd.capture_a = 1'b1;
      end
      S_CAP_B: begin
        if (ir.func == PCOPB) cmd.capture_a = 1'b1;
        else                  cmd.capture_b = 1'b1;
        cmd.op = RD_D;
      end
      S_OPS: begin
        cmd.div_start = (ir.func == DIV);
        cmd.capture_d = (ir.func == PRI);
      end
      S_PTR:     cmd.op = RD_PTR_A;
      S_PTR_CAP: cmd.capture_p = 1'b1;
      S_WB: begin
        if (ir.func == PCOPB) cmd.op = ptr_ok_d() ? WR_PTR : MP_NONE;
        else if (ir.func == PCOPA) cmd.op = ptr_ok ? WR_RES : MP_NONE;
        else if ((ir.func <= OR_) && (ir.func != PRI)) cmd.op = WR_RES;
        else cmd.op = MP_NONE;
      end
      default: cmd.op = MP_NONE;
    endcase
  end

  assign waiting_div = stat.div_busy;

  always_comb begin
    nxt = pc + 11'd1;
    st  = ST_OK;
    if (ir.func == JMP) nxt = 11'(ir.jump_target);
    if (ir.func == JMF && va == '0) nxt = 11'(ir.jump_target);
    if (ir.func == DIV && vb == '0) st = ST_DIV0;
    if (ir.func == PCOPA && !ptr_ok) st = ST_PTR;
    if (ir.func == PCOPB && !ptr_ok_d()) st = ST_PTR;
    if (nxt > 11'(PROGRAM_WORDS)) nxt = 11'(PROGRAM_WORDS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      plen  <= '0;
    end else begin
      if (cfg_valid) plen <= cfg_data;
      case (state)
        S_IDLE: if (in_valid) state <= S_RA;
        S_RA: begin
          if (pc >= len) begin
            res <= '{next_pc: pc[9:0], halted: 1'b1, print_valid: 1'b0,
                     print_addr: '0, print_value: '0, status: ST_OK};
            state <= S_OUT;
          end else state <= S_RB;
        end
        S_RB:    state <= S_CAP_B;
        S_CAP_B: state <= S_OPS;
        S_OPS: begin
          if (ir.func == DIV)        state <= S_DIV;
          else if (ir.func == PCOPA) state <= ptr_ok ? S_PTR : S_WB;
          else                       state <= S_WB;
        end
        S_DIV:     if (!waiting_div) state <= S_WB;
        S_PTR:     state <= S_PTR_CAP;
        S_PTR_CAP: state <= S_WB;
        S_WB: begin
          pc <= nxt;
          res.next_pc     <= nxt[9:0];
          res.halted      <= (nxt >= len);
          res.print_valid <= (ir.func == PRI);
          res.print_addr  <= (ir.func == PRI) ? ir.dest_addr : '0;
          res.print_value <= (ir.func == PRI) ? vd : '0;
          res.status      <= st;
          state <= S_OUT;
        end
        S_OUT:   if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (rst) pc <= 11'(PROGRAM_WORDS))
    else $error("pc past end");
  assert property (@(posedge clk) disable iff (rst) (state == S_DIV) |-> (ir.func == DIV))
    else $error("div state without div");
endmodule

// ===== rtl/memory_to_memory_instruction_executor_top.sv =====
// ----------------------------------------------------------------------------
// memory_to_memory_instruction_executor_top
// Executes one memory-to-memory instruction per input beat.
// ----------------------------------------------------------------------------
// Each instruction reads its operands through the single data memory port,
// runs the operation and writes back before the result is offered; indirect
// loads add a pointer read, and divide waits on a one-bit-per-cycle divider.
// A halted program answers without reading operands. Data memory is not cleared by reset.
module memory_to_memory_instruction_executor_top #(
  parameter int unsigned DATA_WORDS = mmie_pkg::DataWordsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mmie_pkg::instr_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mmie_pkg::result_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [10:0]       cfg_data
);
  import mmie_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  instr_t      ir;
  logic [31:0] va, vb, vd;
  logic        ptr_ok;

  mmie_datapath #(.DATA_WORDS(DATA_WORDS)) u_dp (
    .clk(clk), .rst(rst), .instr(in_data), .cmd(cmd), .stat(stat), .ir(ir),
    .va(va), .vb(vb), .vd(vd), .ptr_ok(ptr_ok)
  );

  mmie_ctrl #(.DATA_WORDS(DATA_WORDS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .ir(ir), .va(va), .vb(vb),
    .vd(vd), .ptr_ok(ptr_ok), .stat(stat), .cmd(cmd), .res(out_data)
  );
endmodule

// ===== verif/memory_to_memory_instruction_executor_top_tb.sv =====
// ----------------------------------------------------------------------------
// memory_to_memory_instruction_executor_top_tb
// Runs instruction streams through the executor and checks every result beat
// against an in-bench model of the data memory, program counter and length.
// A short directed table goes first, then random programs under several
// program lengths, with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module memory_to_memory_instruction_executor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mmie_pkg::*;

  localparam logic [4:0] FN_CALL  = 5'd18;
  localparam logic [4:0] FN_RET   = 5'd19;
  localparam logic [4:0] FN_UNDEF = 5'd31;
  localparam int unsigned DATA_WORDS    = DataWordsDef;
  localparam int unsigned PROGRAM_WORDS = ProgramWordsDef;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  instr_t      in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  memory_to_memory_instruction_executor_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Machine state mirrored by the bench
  logic [31:0] data_mem [DATA_WORDS];
  logic [10:0] pc = '0;
  logic [10:0] prog_len = '0;
  result_t     results_q[$];
  int          errors = 0;
  int          snd_idle = 37;
  int          rcv_idle = 45;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  typedef struct {
    instr_t  ins;
    bit      typed;
    result_t res;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic logic [10:0] eff_len();
    return (prog_len > PROGRAM_WORDS) ? 11'(PROGRAM_WORDS) : prog_len;
  endfunction

  function automatic result_t exec_instr(instr_t x);
    result_t     r;
    logic [31:0] va, vb, p;
    logic [10:0] nxt;
    longint      q;
    r = '0;
    if (pc >= eff_len()) begin
      nxt = pc;
    end else begin
      va  = data_mem[x.src_a_addr];
      vb  = data_mem[x.src_b_addr];
      nxt = pc + 11'd1;
      case (x.func)
        ADD:   data_mem[x.dest_addr] = va + vb;
        SOU:   data_mem[x.dest_addr] = va - vb;
        MUL:   data_mem[x.dest_addr] = va * vb;
        DIV: begin
          if (vb == 0) begin
            data_mem[x.dest_addr] = '0;
            r.status = ST_DIV0;
          end else begin
            q = longint'(signed'(va)) / longint'(signed'(vb));
            data_mem[x.dest_addr] = q[31:0];
          end
        end
        COP:   data_mem[x.dest_addr] = va;
        PCOPA: begin
          if (va < DATA_WORDS) data_mem[x.dest_addr] = data_mem[va[7:0]];
          else r.status = ST_PTR;
        end
        PCOPB: begin
          p = data_mem[x.dest_addr];
          if (p < DATA_WORDS) data_mem[p[7:0]] = va;
          else r.status = ST_PTR;
        end
        AFC:   data_mem[x.dest_addr] = x.immediate;
        PRI: begin
          r.print_valid = 1'b1;
          r.print_addr  = x.dest_addr;
          r.print_value = data_mem[x.dest_addr];
        end
        INF:   data_mem[x.dest_addr] = 32'(signed'(va) <  signed'(vb));
        SUP:   data_mem[x.dest_addr] = 32'(signed'(va) >  signed'(vb));
        INFEQ: data_mem[x.dest_addr] = 32'(signed'(va) <= signed'(vb));
        SUPEQ: data_mem[x.dest_addr] = 32'(signed'(va) >= signed'(vb));
        EQU:   data_mem[x.dest_addr] = 32'(va == vb);
        AND_:  data_mem[x.dest_addr] = 32'(va != 0 && vb != 0);
        OR_:   data_mem[x.dest_addr] = 32'(va != 0 || vb != 0);
        JMP:   nxt = 11'(x.jump_target);
        JMF:   if (va == 0) nxt = 11'(x.jump_target);
        default: ;
      endcase
      if (nxt > PROGRAM_WORDS) nxt = 11'(PROGRAM_WORDS);
      pc = nxt;
    end
    r.next_pc = nxt[9:0];
    r.halted  = (nxt >= eff_len());
    return r;
  endfunction

  function automatic instr_t mk(logic [4:0] f, logic [7:0] d, logic [7:0] a, logic [7:0] b,
                               logic [31:0] imm, logic [9:0] tgt);
    instr_t x;
    x.func = f; x.dest_addr = d; x.src_a_addr = a; x.src_b_addr = b;
    x.immediate = imm; x.jump_target = tgt;
    return x;
  endfunction

  function automatic result_t res(logic [9:0] npc, logic h, logic pv, logic [7:0] pa,
                                  logic [31:0] pval, logic [1:0] st);
    result_t r;
    r.next_pc = npc; r.halted = h; r.print_valid = pv; r.print_addr = pa;
    r.print_value = pval; r.status = st;
    return r;
  endfunction

  task automatic send_instr(input instr_t x, input bit typed, input result_t given,
                            output bit executed);
    result_t r;
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    executed = (pc < eff_len());
    r = exec_instr(x);
    results_q.push_back(typed ? given : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_len(input logic [10:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    prog_len = v;
  endtask

  function automatic instr_t random_instr();
    instr_t      x;
    int          sel;
    logic [10:0] len;
    logic [95:0] rnd;
    len = eff_len();
    sel = $urandom_range(99);
    rnd = {$urandom, $urandom, $urandom};
    x = rnd[$bits(instr_t)-1:0];
    if (len != 0 && (pc + 3 >= len || sel < 5)) begin
      x.func = (sel & 1) ? JMP : JMF;
      x.jump_target = 10'($urandom_range(len - 1));
    end else if (sel < 15) begin
      // seed a valid pointer so the indirect ops get past the range check
      x.func = AFC;
      x.immediate = $urandom_range(DATA_WORDS - 1);
    end else if (sel < 19) begin
      x.func = 5'($urandom_range(FN_UNDEF, FN_CALL));
    end else begin
      x.func = 5'($urandom_range(JMF));
      if (x.func inside {JMP, JMF} && len != 0) x.jump_target = 10'($urandom_range(len - 1));
    end
    return x;
  endfunction

  task automatic run_phase(input logic [10:0] len, input int n, input int s_idle,
                           input int r_idle, input bit long_hold);
    bit done;
    int count, tries;
    drain();
    if (pc < eff_len()) begin
      send_instr(mk(JMP, 0, 0, 0, 0, 0), 1'b0, '0, done);
      drain();
    end
    write_len(len);
    snd_idle = s_idle;
    rcv_idle = r_idle;
    if (long_hold) hold_req = 1'b1;
    count = 0;
    tries = 0;
    while (count < n && tries < 3 * n) begin
      send_instr(random_instr(), 1'b0, '0, done);
      count += done;
      tries++;
    end
  endtask

  function automatic void cmp(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h, actual %0h", name, e, a);
      errors++;
    end
  endfunction

  // Result side: random stall, long hold on request, check each beat
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = results_q.pop_front();
          cmp("next_pc", 32'(e.next_pc), 32'(out_data.next_pc));
          cmp("halted", 32'(e.halted), 32'(out_data.halted));
          cmp("print_valid", 32'(e.print_valid), 32'(out_data.print_valid));
          cmp("print_addr", 32'(e.print_addr), 32'(out_data.print_addr));
          cmp("print_value", e.print_value, out_data.print_value);
          cmp("status", 32'(e.status), 32'(out_data.status));
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left <= 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle);
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    bit          done;
    logic [31:0] w;
    // halted at reset length
    dir_rows.push_back('{mk(ADD, 1, 2, 3, 0, 0), 1'b1, res(0, 1, 0, 0, 0, ST_OK)});
    dir_rows.push_back('{mk(PRI, 255, 0, 0, 0, 0), 1'b1, res(0, 1, 0, 0, 0, ST_OK)});
    dir_rows.push_back('{mk(JMP, 0, 0, 0, 0, 1023), 1'b1, res(0, 1, 0, 0, 0, ST_OK)});
    // executing from pc 256 with length 1024
    dir_rows.push_back('{mk(DIV, 20, 1, 0, 0, 0), 1'b1, res(257, 0, 0, 0, 0, ST_DIV0)});
    dir_rows.push_back('{mk(DIV, 21, 3, 2, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(PCOPA, 22, 6, 0, 0, 0), 1'b1, res(259, 0, 0, 0, 0, ST_PTR)});
    dir_rows.push_back('{mk(PCOPA, 23, 7, 0, 0, 0), 1'b1, res(260, 0, 0, 0, 0, ST_PTR)});
    dir_rows.push_back('{mk(PCOPB, 6, 1, 0, 0, 0), 1'b1, res(261, 0, 0, 0, 0, ST_PTR)});
    dir_rows.push_back('{mk(PCOPB, 5, 4, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(PCOPA, 24, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(ADD, 25, 4, 1, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(SOU, 26, 3, 1, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(MUL, 27, 4, 4, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(COP, 28, 3, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(AFC, 29, 0, 0, 32'h8000_0000, 0), 1'b0, '0});
    dir_rows.push_back('{mk(AFC, 255, 0, 0, 32'h7FFF_FFFF, 0), 1'b0, '0});
    dir_rows.push_back('{mk(PRI, 255, 0, 0, 0, 0), 1'b1,
                         res(270, 0, 1, 255, 32'h7FFF_FFFF, ST_OK)});
    dir_rows.push_back('{mk(INF, 30, 3, 4, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(SUP, 31, 3, 4, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(INFEQ, 32, 2, 2, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(SUPEQ, 33, 1, 2, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(EQU, 34, 2, 2, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(AND_, 35, 0, 1, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(OR_, 36, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(JMF, 0, 1, 0, 0, 1023), 1'b0, '0});
    dir_rows.push_back('{mk(JMF, 0, 0, 0, 0, 600), 1'b1, res(600, 0, 0, 0, 0, ST_OK)});
    dir_rows.push_back('{mk(JMP, 0, 0, 0, 0, 0), 1'b1, res(0, 0, 0, 0, 0, ST_OK)});
    dir_rows.push_back('{mk(FN_CALL, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(FN_RET, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(FN_UNDEF, 0, 0, 0, 0, 0), 1'b0, '0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (k == 3) begin
        // write every data word before anything reads one
        drain();
        write_len(11'd1024);
        for (int i = 0; i < DATA_WORDS; i++) begin
          case (i)
            0: w = 32'd0;
            1: w = 32'd1;
            2: w = 32'hFFFF_FFFF;
            3: w = 32'h8000_0000;
            4: w = 32'h7FFF_FFFF;
            5: w = 32'd5;
            6: w = 32'd300;
            7: w = 32'hFFFF_FFFD;
            default: w = ($urandom_range(1)) ? $urandom_range(DATA_WORDS - 1) : $urandom;
          endcase
          send_instr(mk(AFC, i[7:0], 0, 0, w, 0), 1'b0, '0, done);
        end
      end
      send_instr(dir_rows[k].ins, dir_rows[k].typed, dir_rows[k].res, done);
    end

    run_phase(11'd1024, 200, 37, 45, 1'b0);
    run_phase(11'd17,    80, 37, 45, 1'b1);
    run_phase(11'd2047, 150, 45, 37, 1'b0);
    run_phase(11'd300,  120, 45, 37, 1'b0);
    run_phase(11'd0,     10,  0,  0, 1'b0);
    run_phase(11'd1024, 120,  0,  0, 1'b0);

    // run off the end of the program space, then stay halted
    send_instr(mk(JMP, 0, 0, 0, 0, 1023), 1'b0, '0, done);
    send_instr(mk(ADD, 40, 1, 1, 0, 0), 1'b0, '0, done);
    send_instr(mk(PRI, 40, 0, 0, 0, 0), 1'b0, '0, done);
    send_instr(mk(JMP, 0, 0, 0, 0, 0), 1'b0, '0, done);
    drain();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mmie_pkg.sv
rtl/mmie_div.sv
rtl/mmie_datapath.sv
rtl/mmie_ctrl.sv
rtl/memory_to_memory_instruction_executor_top.sv
verif/memory_to_memory_instruction_executor_top_tb.sv
